>>> src/lcf_pkg.sv
// Shared types and constants for the linear convolution FIR.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps

package lcf_pkg;

  // Field widths fixed by the word formats
  localparam int SAMPLE_W     = 16;
  localparam int TAP_IDX_W    = 6;
  localparam int Y_W          = 40;
  localparam int CFG_W        = 7;
  localparam int MAX_TAPS_DEF = 64;

  // Input word mode codes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic [TAP_IDX_W-1:0]       tap_index;
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } in_word_t;

  typedef struct packed {
    logic signed [Y_W-1:0] y_value;
    logic                  last_out;
  } out_word_t;

  // Controls broadcast to every cell of the chain
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

>>> src/lcf_cell.sv
// One tap cell of the FIR chain: coefficient, delayed sample, product and partial sum.
// Depends on lcf_pkg.
`timescale 1ns / 1ps

module lcf_cell
  import lcf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  cell_ctl_t                  ctl,
  input  logic                       coef_we,
  input  logic signed [SAMPLE_W-1:0] coef_in,
  input  logic signed [SAMPLE_W-1:0] samp_in,
  output logic signed [SAMPLE_W-1:0] samp_out,
  input  logic                       start,
  input  logic                       tok_in,
  input  logic signed [Y_W-1:0]      sum_in,
  output logic                       tok_out,
  output logic signed [Y_W-1:0]      sum_out
);

  logic signed [SAMPLE_W-1:0]   coef_r, coef_nxt;
  logic signed [SAMPLE_W-1:0]   samp_r, samp_nxt;
  logic signed [Y_W-1:0]        prod_r, prod_nxt;
  logic signed [Y_W-1:0]        sum_r, sum_nxt;
  logic                         tok_r, tok_nxt;
  logic signed [2*SAMPLE_W-1:0] prod_full;

  // Load coefficient on a matching write
  always_comb begin
    coef_nxt = coef_we ? coef_in : coef_r;
  end

  // Clear, advance or hold the delayed sample
  always_comb begin
    if (ctl.clear) begin
      samp_nxt = '0;
    end else if (ctl.shift) begin
      samp_nxt = samp_in;
    end else begin
      samp_nxt = samp_r;
    end
  end

  // Product of this tap, sign extended to the sum width
  assign prod_full = coef_r * samp_r;
  assign prod_nxt  = Y_W'(prod_full);

  // Add this tap when the partial-sum token passes through
  always_comb begin
    tok_nxt = start | tok_in;
    if (start) begin
      sum_nxt = prod_r;
    end else if (tok_in) begin
      sum_nxt = sum_in + prod_r;
    end else begin
      sum_nxt = sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samp_r <= '0;
      tok_r  <= 1'b0;
    end else begin
      samp_r <= samp_nxt;
      tok_r  <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    coef_r <= coef_nxt;
    prod_r <= prod_nxt;
    sum_r  <= sum_nxt;
  end

  assign samp_out = samp_r;
  assign tok_out  = tok_r;
  assign sum_out  = sum_r;

endmodule

>>> src/linear_convolution_fir.sv
// Top level of the linear convolution FIR: cell chain, sequencer and output register.
// Depends on lcf_pkg and lcf_cell.
//
//   port group   dir   carries
//   in_*         in    in_word_t: coefficient load or sample, last flag
//   out_*        out   out_word_t: 40-bit convolution sum, last_out flag
//   cfg_*        in    num_taps (7 bits), taken in any cycle
//
// A coefficient load is accepted in S_IDLE and leaves in_ready high. A sample
// is taken through S_MUL, S_RUN and S_DONE before the next one is accepted: the
// partial sum walks the cell chain one tap per cycle, from the last tap in use
// down to tap 0. A sample marked last then adds num_taps-1 tail outputs before
// in_ready rises again. Reset (rst_n low, synchronous) zeroes the sample history
// and sets num_taps to 1; coefficients hold no reset value.
// A stalled output only holds the sequencer once a second result is ready.
`timescale 1ns / 1ps

module linear_convolution_fir
  import lcf_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_word,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_num_taps
);

  localparam int IDX_W = $clog2(MAX_TAPS);
  localparam int CW    = ($clog2(MAX_TAPS + 1) > CFG_W) ? $clog2(MAX_TAPS + 1) : CFG_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_RUN  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic             start_r, start_nxt;
  logic [IDX_W-1:0] taps_m1_r, taps_m1_nxt;
  logic [IDX_W-1:0] flush_left_r, flush_left_nxt;
  logic             last_seq_r, last_seq_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  logic             in_acc;
  logic             coef_wr;
  logic             out_free;
  logic [CW-1:0]    cfg_ext;
  cell_ctl_t        ctl;

  logic signed [SAMPLE_W-1:0] samp_chain [MAX_TAPS+1];
  logic signed [Y_W-1:0]      sum_chain  [MAX_TAPS+1];
  logic                       tok_chain  [MAX_TAPS+1];

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign coef_wr   = in_acc & (in_word.mode == MODE_LOAD);
  assign out_free  = ~out_valid_r | out_ready;
  assign cfg_ready = 1'b1;

  // Clamp the tap count into 1..MAX_TAPS and keep it minus one
  always_comb begin
    cfg_ext     = CW'(cfg_num_taps);
    taps_m1_nxt = taps_m1_r;
    if (cfg_valid) begin
      if (cfg_ext == '0) begin
        taps_m1_nxt = '0;
      end else if (cfg_ext > CW'(MAX_TAPS)) begin
        taps_m1_nxt = IDX_W'(MAX_TAPS - 1);
      end else begin
        taps_m1_nxt = IDX_W'(cfg_ext - 1'b1);
      end
    end
  end

  // Sequencer: shift, let products settle, walk the sum, deliver
  always_comb begin
    state_nxt      = state_r;
    start_nxt      = 1'b0;
    flush_left_nxt = flush_left_r;
    last_seq_nxt   = last_seq_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_word_nxt   = out_word_r;
    ctl.shift      = 1'b0;
    ctl.clear      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_word.mode == MODE_SAMPLE) begin
          ctl.shift      = 1'b1;
          last_seq_nxt   = in_word.last;
          flush_left_nxt = in_word.last ? taps_m1_r : '0;
          state_nxt      = S_MUL;
        end
      end
      S_MUL: begin
        start_nxt = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (tok_chain[0]) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_word_nxt.y_value  = sum_chain[0];
          out_word_nxt.last_out = last_seq_r & (flush_left_r == '0);
          if (flush_left_r != '0) begin
            ctl.shift      = 1'b1;
            flush_left_nxt = IDX_W'(flush_left_r - 1'b1);
            state_nxt      = S_MUL;
          end else begin
            ctl.clear    = last_seq_r;
            last_seq_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      start_r      <= 1'b0;
      taps_m1_r    <= '0;
      flush_left_r <= '0;
      last_seq_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      start_r      <= start_nxt;
      taps_m1_r    <= taps_m1_nxt;
      flush_left_r <= flush_left_nxt;
      last_seq_r   <= last_seq_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  // Newest sample enters at tap 0; tail flush feeds zeros
  assign samp_chain[0]        = (state_r == S_IDLE) ? in_word.value : '0;
  assign sum_chain[MAX_TAPS]  = '0;
  assign tok_chain[MAX_TAPS]  = 1'b0;

  // Chain of tap cells: samples move up, partial sums move down
  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    logic cell_start;
    logic cell_we;

    assign cell_start = start_r & (taps_m1_r == IDX_W'(i));
    assign cell_we    = coef_wr & (32'(in_word.tap_index) == i);

    lcf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .coef_we  (cell_we),
      .coef_in  (in_word.value),
      .samp_in  (samp_chain[i]),
      .samp_out (samp_chain[i+1]),
      .start    (cell_start),
      .tok_in   (tok_chain[i+1]),
      .sum_in   (sum_chain[i+1]),
      .tok_out  (tok_chain[i]),
      .sum_out  (sum_chain[i])
    );
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
